// ===== rtl/core/lfba_pkg.sv =====
// ----------------------------------------------------------------------------
// Lowest free identifier allocator: shared definitions
// Field widths, command and status codes, controller-to-datapath command and
// status structures, and the padding mask for a partly used bitmap word.
// ----------------------------------------------------------------------------
package lfba_pkg;

   localparam int NUM_IDS_DEF = 256;

   localparam int CMD_W      = 2;
   localparam int ID_IN_W    = 12;
   localparam int ID_OUT_W   = 13;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // Bitmap organisation: words of 64 identifiers, words grouped by eight.
   localparam int WORD_W   = 64;
   localparam int BIT_AW   = 6;
   localparam int GRP_ROWS = 8;
   localparam int SUB_AW   = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_QUERY   = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_GROUP,
      OP_ROW,
      OP_SCAN,
      OP_CHECK,
      OP_ACCESS,
      OP_RANGE
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load;
   } dp_ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    id_ok;
      logic    all_full;
      logic    slot_free;
   } dp_sts_type;

   // Bits of the last word that lie beyond the identifier range read as used.
   function automatic logic [WORD_W-1:0] last_pad(input int num_ids);
      logic [WORD_W-1:0] mask;
      int                used;
      used = num_ids - ((num_ids + WORD_W - 1) / WORD_W - 1) * WORD_W;
      for (int b = 0; b < WORD_W; b++) begin
         mask[b] = (b >= used);
      end
      return mask;
   endfunction

endpackage

// ===== rtl/core/lfba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Lowest free identifier allocator: controller
// Sequences one request at a time through the datapath and hands the result
// to the output register once it is free.
// ----------------------------------------------------------------------------
module lfba_ctrl
   import lfba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  dp_sts_type sts,
   output dp_ctl_type ctl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_ROW,
      S_SCAN,
      S_ACCESS,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl.op   = OP_NONE;
      ctl.load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.op   = OP_CAPTURE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.cmd)
               CMD_ALLOC: begin
                  ctl.op   = OP_GROUP;
                  state_in = sts.all_full ? S_FINISH : S_ROW;
               end
               CMD_RELEASE, CMD_QUERY: begin
                  if (sts.id_ok) begin
                     ctl.op   = OP_CHECK;
                     state_in = S_ACCESS;
                  end else begin
                     ctl.op   = OP_RANGE;
                     state_in = S_FINISH;
                  end
               end
               default: begin
                  ctl.op   = OP_RANGE;
                  state_in = S_FINISH;
               end
            endcase
         end
         S_ROW: begin
            ctl.op   = OP_ROW;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            ctl.op   = OP_SCAN;
            state_in = S_FINISH;
         end
         S_ACCESS: begin
            ctl.op   = OP_ACCESS;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (sts.slot_free) begin
               ctl.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/lfba_dpath.sv =====
// ----------------------------------------------------------------------------
// Lowest free identifier allocator: datapath
// Holds the bitmap in a word memory with per-word valid and full flags, runs
// the two-level search for a free word and the bit search within it, and
// keeps the result register.
// ----------------------------------------------------------------------------
module lfba_dpath
   import lfba_pkg::*;
#(
   parameter int NUM_IDS = NUM_IDS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_ctl_type            ctl,
   output dp_sts_type            sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int NUM_ROWS = (NUM_IDS + WORD_W - 1) / WORD_W;
   localparam int NUM_GRPS = (NUM_ROWS + GRP_ROWS - 1) / GRP_ROWS;
   localparam int PAD_ROWS = NUM_GRPS * GRP_ROWS;
   localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int GRP_AW   = (NUM_GRPS > 1) ? $clog2(NUM_GRPS) : 1;
   localparam int PAD_AW   = $clog2(PAD_ROWS);
   localparam logic [WORD_W-1:0] LAST_PAD = last_pad(NUM_IDS);

   logic [WORD_W-1:0]   mem [NUM_ROWS];

   cmd_type             cmd_ff;
   logic [ID_IN_W-1:0]  id_ff;
   logic [GRP_AW-1:0]   grp_ff;
   logic [ROW_AW-1:0]   row_ff;
   logic [BIT_AW-1:0]   bit_ff;
   logic [WORD_W-1:0]   rd_data_ff;
   logic [PAD_ROWS-1:0] row_full_ff;
   logic [NUM_ROWS-1:0] row_valid_ff;

   logic [ID_OUT_W-1:0] res_id_ff;
   status_type          res_status_ff;
   logic                res_in_use_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                rsp_valid_ff;

   logic [NUM_GRPS-1:0] grp_full;
   logic [GRP_AW-1:0]   grp_pick;
   logic [GRP_ROWS-1:0] sub_flags;
   logic [SUB_AW-1:0]   sub_pick;
   logic [ROW_AW-1:0]   row_pick;
   logic [ID_IN_W-1:0]  id_m1;
   logic [ROW_AW-1:0]   rd_addr;
   logic                rd_en;
   logic [WORD_W-1:0]   word_eff;
   logic [WORD_W-1:0]   word_pad;
   logic [BIT_AW-1:0]   free_bit;
   logic [WORD_W-1:0]   free_mask;
   logic [WORD_W-1:0]   clr_mask;
   logic [WORD_W-1:0]   alloc_word;

   // Group level of the search: a group is full when all its words are.
   always_comb begin
      grp_pick = '0;
      for (int g = 0; g < NUM_GRPS; g++) begin
         grp_full[g] = &row_full_ff[g*GRP_ROWS +: GRP_ROWS];
      end
      for (int g = NUM_GRPS - 1; g >= 0; g--) begin
         if (!grp_full[g]) begin
            grp_pick = GRP_AW'(g);
         end
      end
   end

   // Word level of the search within the chosen group.
   always_comb begin
      sub_flags = row_full_ff[PAD_AW'({grp_ff, SUB_AW'(0)}) +: GRP_ROWS];
      sub_pick  = '0;
      for (int s = GRP_ROWS - 1; s >= 0; s--) begin
         if (!sub_flags[s]) begin
            sub_pick = SUB_AW'(s);
         end
      end
      row_pick = ROW_AW'({grp_ff, sub_pick});
   end

   assign id_m1   = id_ff - ID_IN_W'(1);
   assign rd_en   = (ctl.op == OP_ROW) || (ctl.op == OP_CHECK);
   assign rd_addr = (ctl.op == OP_ROW) ? row_pick : ROW_AW'(id_m1 >> BIT_AW);

   // A word never written since reset reads as all free.
   assign word_eff = row_valid_ff[row_ff] ? rd_data_ff : '0;
   assign word_pad = word_eff | ((row_ff == ROW_AW'(NUM_ROWS - 1)) ? LAST_PAD : '0);

   always_comb begin
      free_bit = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (!word_pad[b]) begin
            free_bit = BIT_AW'(b);
         end
      end
   end

   assign free_mask  = WORD_W'(1) << free_bit;
   assign clr_mask   = WORD_W'(1) << bit_ff;
   assign alloc_word = word_eff | free_mask;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (ctl.op == OP_SCAN) begin
         mem[row_ff] <= alloc_word;
      end else if ((ctl.op == OP_ACCESS) && (cmd_ff == CMD_RELEASE)) begin
         mem[row_ff] <= word_eff & ~clr_mask;
      end
   end

   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_CAPTURE: begin
            cmd_ff <= cmd_type'(req_tdata[CMD_W-1:0]);
            id_ff  <= req_tdata[CMD_W +: ID_IN_W];
         end
         OP_GROUP: begin
            grp_ff        <= grp_pick;
            res_id_ff     <= '0;
            res_status_ff <= ST_FULL;
            res_in_use_ff <= 1'b0;
         end
         OP_ROW: begin
            row_ff <= row_pick;
         end
         OP_SCAN: begin
            res_id_ff     <= ID_OUT_W'({row_ff, free_bit}) + ID_OUT_W'(1);
            res_status_ff <= ST_OK;
         end
         OP_CHECK: begin
            row_ff <= rd_addr;
            bit_ff <= id_m1[BIT_AW-1:0];
         end
         OP_ACCESS: begin
            res_id_ff     <= '0;
            res_status_ff <= ST_OK;
            res_in_use_ff <= (cmd_ff == CMD_QUERY) && word_eff[bit_ff];
         end
         OP_RANGE: begin
            res_id_ff     <= '0;
            res_status_ff <= ST_RANGE;
            res_in_use_ff <= 1'b0;
         end
         default: begin
         end
      endcase
      if (ctl.load) begin
         rsp_data_ff <= {res_in_use_ff, res_status_ff, res_id_ff};
      end
   end

   // Word flags. Words past the end of the range stay marked full for good.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAD_ROWS; i++) begin
            row_full_ff[i] <= (i >= NUM_ROWS);
         end
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.op == OP_SCAN) begin
            row_full_ff[PAD_AW'(row_ff)] <=
               &(alloc_word | ((row_ff == ROW_AW'(NUM_ROWS - 1)) ? LAST_PAD : '0));
            row_valid_ff[row_ff] <= 1'b1;
         end else if ((ctl.op == OP_ACCESS) && (cmd_ff == CMD_RELEASE)) begin
            row_full_ff[PAD_AW'(row_ff)] <= 1'b0;
            row_valid_ff[row_ff]         <= 1'b1;
         end
         if (ctl.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.cmd       = cmd_ff;
   assign sts.id_ok     = (id_ff != '0) && ({1'b0, id_ff} <= ID_OUT_W'(NUM_IDS));
   assign sts.all_full  = &grp_full;
   assign sts.slot_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The bit search only runs on a word that the group search saw as not full.
   a_scan_not_full: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_SCAN |-> !row_full_ff[PAD_AW'(row_ff)])
      else $error("bit search started on a full word");

   // A written word must afterwards be read from memory, not as all free.
   a_scan_marks_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_SCAN |=> row_valid_ff[$past(row_ff)])
      else $error("allocated word not marked valid");

   // The result register is never overwritten while a result still waits.
   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while occupied");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

// ===== rtl/core/lowest_free_id_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// Lowest free identifier allocator
// Allocates the lowest free identifier in 1..NUM_IDS, releases and queries
// identifiers, over an in-use bitmap held in a word memory.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one request: allocate, release or query. Each
//   request yields exactly one response on the rsp channel with the
//   allocated identifier, a status code and the query answer.
//   Requests are taken one at a time. An allocate that finds a free
//   identifier passes from acceptance to the next acceptance through group
//   search, word search with the memory read, bit search with write-back and
//   result hand-off; a release or a query through the identifier check with
//   the memory read, the access and the hand-off, and an allocate that finds
//   every identifier in use, an out-of-range identifier or an unknown command
//   through decode and the hand-off alone. The response appears in the output
//   register in the same cycle that the block is ready again. The memory port
//   and the two-level search set these steps.
//   A response waiting in the output register does not block the next
//   request; the block only holds its finished result while the receiver
//   stalls and the register is still occupied, and takes no new request then.
//   After reset every identifier is free at once; no clearing pass is run,
//   since per-word valid flags mark words not yet written as all free.
// ----------------------------------------------------------------------------
module lowest_free_id_bitmap_allocator
   import lfba_pkg::*;
#(
   parameter int NUM_IDS = NUM_IDS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // command[1:0], id_in[13:2], zero[15:14]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // id_out[12:0], status[14:13], in_use[15]
);

   dp_ctl_type ctl;
   dp_sts_type sts;

   lfba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   lfba_dpath #(
      .NUM_IDS (NUM_IDS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== bench/lowest_free_id_bitmap_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lowest free identifier allocator: self-checking bench
// Drives allocate, release and query requests with random gaps on both
// channels. An identifier pool tracker predicts every response and compares
// it field by field with what the allocator returns.
// ----------------------------------------------------------------------------

import lfba_pkg::*;

typedef struct {
   logic [ID_OUT_W-1:0] id_out;
   status_type          status;
   logic                in_use;
} alloc_result_type;

class id_pool_tracker;
   localparam int POOL_SIZE = NUM_IDS_DEF;

   bit               taken[POOL_SIZE];
   alloc_result_type awaited[$];
   int               errors;
   int               n_requests;
   int               n_granted;
   int               n_full;
   int               n_range;
   int               n_busy_hits;

   function new();
      foreach (taken[i]) taken[i] = 1'b0;
      errors      = 0;
      n_requests  = 0;
      n_granted   = 0;
      n_full      = 0;
      n_range     = 0;
      n_busy_hits = 0;
   endfunction

   task report(input string what, input int got, input int want);
      $display("mismatch on response %0d: %s got %0d, want %0d",
               n_requests - awaited.size(), what, got, want);
      errors++;
   endtask

   // Works out the response of one accepted request and updates the pool.
   function void note_request(input logic [CMD_W-1:0] cmd, input logic [ID_IN_W-1:0] id);
      alloc_result_type res;
      bit               id_ok;
      bit               found;
      res.id_out = '0;
      res.status = ST_OK;
      res.in_use = 1'b0;
      id_ok = (id >= 1) && (id <= POOL_SIZE);
      found = 1'b0;
      n_requests++;
      case (cmd)
         CMD_ALLOC: begin
            for (int k = 0; k < POOL_SIZE; k++) begin
               if (!found && !taken[k]) begin
                  taken[k]   = 1'b1;
                  res.id_out = ID_OUT_W'(k + 1);
                  found      = 1'b1;
               end
            end
            if (found) begin
               n_granted++;
            end else begin
               res.status = ST_FULL;
               n_full++;
            end
         end
         CMD_RELEASE: begin
            if (id_ok) taken[id - 1] = 1'b0;
            else res.status = ST_RANGE;
         end
         CMD_QUERY: begin
            if (id_ok) begin
               res.in_use = taken[id - 1];
               if (res.in_use) n_busy_hits++;
            end else begin
               res.status = ST_RANGE;
            end
         end
         default: res.status = ST_RANGE;
      endcase
      if (res.status == ST_RANGE) n_range++;
      awaited.push_back(res);
   endfunction

   task check_response(input logic [RSP_DATA_W-1:0] data);
      alloc_result_type want;
      if (awaited.size() == 0) begin
         report("unexpected response, data", int'(data), 0);
      end else begin
         want = awaited.pop_front();
         if (data[12:0] !== want.id_out) report("id_out", int'(data[12:0]), int'(want.id_out));
         if (data[14:13] !== want.status) report("status", int'(data[14:13]), int'(want.status));
         if (data[15] !== want.in_use) report("in_use", int'(data[15]), int'(want.in_use));
      end
   endtask

   function int pending();
      return awaited.size();
   endfunction
endclass

module lowest_free_id_bitmap_allocator_tb;
   import lfba_pkg::*;

   localparam int                 NUM_IDS    = NUM_IDS_DEF;
   localparam int                 RANDOM_REQ = 2000;
   localparam int                 QUIET_MAX  = 1000;
   localparam int                 TAIL       = 20;
   localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
   localparam logic [ID_IN_W-1:0] ID_TOP     = 12'hFFF;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   id_pool_tracker pool = new();
   int             n_sent      = 0;
   int             quiet_count = 0;
   bit             req_steady  = 1'b0;

   lowest_free_id_bitmap_allocator #(.NUM_IDS(NUM_IDS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap(input bit steady);
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ID_IN_W-1:0] pick_id();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 8) return ID_IN_W'($urandom_range(1, NUM_IDS));
      if (roll == 8) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return ID_IN_W'(1);
            2: return ID_IN_W'(NUM_IDS);
            default: return ID_IN_W'(NUM_IDS + 1);
         endcase
      end
      return ID_IN_W'($urandom_range(0, 4095));
   endfunction

   task send_request(input logic [CMD_W-1:0] cmd, input logic [ID_IN_W-1:0] id);
      int gap;
      gap = pick_gap(req_steady);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, id, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_sent++;
   endtask

   // Holds the request side idle until every response has come back.
   task hold_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pool.pending() != 0) @(negedge clock);
   endtask

   task send_mixed();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) send_request(CMD_ALLOC, ID_IN_W'($urandom_range(0, 4095)));
      else if (roll < 70) send_request(CMD_RELEASE, pick_id());
      else if (roll < 95) send_request(CMD_QUERY, pick_id());
      else send_request(CMD_UNUSED, ID_IN_W'($urandom_range(0, 4095)));
   endtask

   // The receiver stalls at random, with the odd long stretch of readiness.
   initial begin
      int stall;
      forever begin
         stall = pick_gap(1'b0);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 7) == 0) repeat (64) @(negedge clock);
         else repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) pool.note_request(req_tdata[1:0], req_tdata[13:2]);
         if (rsp_tvalid && rsp_tready) pool.check_response(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_count <= 0;
         end else if (quiet_count >= QUIET_MAX) begin
            $display("timeout after %0d cycles with no handshake", quiet_count);
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            quiet_count <= quiet_count + 1;
         end
      end
   end

   initial begin
      int round;
      int kind;
      int directed;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Boundary and out-of-range identifiers, the unused command code, allocate ignoring
      // its identifier, and release of an identifier that is already free.
      send_request(CMD_QUERY, ID_IN_W'(1));
      send_request(CMD_QUERY, '0);
      send_request(CMD_QUERY, ID_IN_W'(NUM_IDS));
      send_request(CMD_QUERY, ID_IN_W'(NUM_IDS + 1));
      send_request(CMD_QUERY, ID_TOP);
      send_request(CMD_RELEASE, '0);
      send_request(CMD_RELEASE, ID_TOP);
      send_request(CMD_RELEASE, ID_IN_W'(NUM_IDS + 1));
      send_request(CMD_UNUSED, '0);
      send_request(CMD_UNUSED, ID_TOP);
      send_request(CMD_ALLOC, ID_TOP);
      send_request(CMD_ALLOC, '0);
      send_request(CMD_ALLOC, ID_IN_W'(12'hAAA));
      send_request(CMD_QUERY, ID_IN_W'(2));
      send_request(CMD_RELEASE, ID_IN_W'(2));
      send_request(CMD_QUERY, ID_IN_W'(2));
      send_request(CMD_RELEASE, ID_IN_W'(2));
      send_request(CMD_ALLOC, ID_IN_W'(12'h555));
      send_request(CMD_RELEASE, ID_IN_W'(NUM_IDS));
      send_request(CMD_QUERY, ID_IN_W'(3));
      send_request(CMD_RELEASE, ID_IN_W'(1));
      send_request(CMD_ALLOC, '0);
      directed = n_sent;
      hold_until_drained();

      round = 0;
      while (n_sent < directed + RANDOM_REQ) begin
         req_steady = ($urandom_range(0, 3) == 0);
         if (round == 0 || round == 3) kind = 0;
         else if (round == 1) kind = 1;
         else kind = $urandom_range(0, 5);
         case (kind)
            0: begin
               // Fill the pool completely, then run past full.
               repeat (NUM_IDS + 8) begin
                  if ($urandom_range(0, 9) == 0) send_request(CMD_QUERY, pick_id());
                  send_request(CMD_ALLOC, ID_IN_W'($urandom_range(0, 4095)));
               end
            end
            1: begin
               hold_until_drained();
               repeat (120) begin
                  if ($urandom_range(0, 4) == 0) send_request(CMD_QUERY, pick_id());
                  else send_request(CMD_RELEASE, pick_id());
               end
            end
            default: repeat (100) send_mixed();
         endcase
         round++;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pool.pending() != 0) @(negedge clock);
      repeat (TAIL) @(negedge clock);

      $display("%0d requests in %0d rounds: %0d identifiers granted, %0d allocates when full,",
               pool.n_requests, round, pool.n_granted, pool.n_full);
      $display("%0d out-of-range or unknown requests, %0d queries found in use, %0d mismatches",
               pool.n_range, pool.n_busy_hits, pool.errors);
      if (pool.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
